>>> rtl/gcot_pkg.sv
`timescale 1ns / 1ps

package gcot_pkg;

    typedef enum logic [2:0] {
        OP_PLACE     = 3'd0,
        OP_PURGE     = 3'd1,
        OP_READ      = 3'd2,
        OP_COMMIT    = 3'd3,
        OP_BLACKLIST = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_WALK,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic        bad_coord;
        logic        cell_usable;
        logic [15:0] conflicted_id;
        logic [15:0] pending_id;
        logic [15:0] occupant_id;
        logic        ok;
    } res_t;

    localparam int RES_W       = $bits(res_t);
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int IN_TDATA_W  = 32;

endpackage

>>> rtl/gcot_ram.sv
`timescale 1ns / 1ps

module gcot_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 50,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/gcot_cell.sv
`timescale 1ns / 1ps

module gcot_cell #(
    parameter int ID_BITS = 16
) (
    input  gcot_pkg::op_t        op,
    input  logic [ID_BITS-1:0]   id,
    input  logic [3*ID_BITS+1:0] entry_q,
    output logic [3*ID_BITS+1:0] entry_d,
    output gcot_pkg::res_t       res
);

    import gcot_pkg::*;

    localparam int BL_BIT = 3 * ID_BITS;
    localparam int ST_BIT = 3 * ID_BITS + 1;

    logic [ID_BITS-1:0] cur;
    logic [ID_BITS-1:0] pend;
    logic [ID_BITS-1:0] conf;
    logic               bl;
    logic               st;
    logic [ID_BITS-1:0] n_cur;
    logic [ID_BITS-1:0] n_pend;
    logic [ID_BITS-1:0] n_conf;
    logic               n_bl;
    logic               n_st;
    logic               ok;
    logic               vacant;

    assign cur  = entry_q[ID_BITS-1:0];
    assign pend = entry_q[2*ID_BITS-1:ID_BITS];
    assign conf = entry_q[3*ID_BITS-1:2*ID_BITS];
    assign bl   = entry_q[BL_BIT];
    assign st   = entry_q[ST_BIT];

    assign vacant = (pend == '0) || ((pend == cur) && !st);

    always_comb
    begin
        n_cur  = cur;
        n_pend = pend;
        n_conf = conf;
        n_bl   = bl;
        n_st   = st;
        ok     = 1'b0;
        unique case (op)
            OP_PLACE:
            begin
                if (bl)
                begin
                    ok = (id == '0) || (id == pend);
                end
                else if (vacant)
                begin
                    n_pend = id;
                    if (id == cur)
                    begin
                        n_st = 1'b1;
                    end
                    ok = 1'b1;
                end
                else if ((id == '0) || (id == pend))
                begin
                    ok = 1'b1;
                end
                else
                begin
                    n_conf = id;
                end
            end
            OP_PURGE:
            begin
                if (id == pend)
                begin
                    if (conf != '0)
                    begin
                        n_st   = (conf == cur);
                        n_pend = conf;
                        n_conf = '0;
                    end
                    else
                    begin
                        n_st   = 1'b0;
                        n_pend = cur;
                    end
                    ok = 1'b1;
                end
                else if (id == conf)
                begin
                    n_conf = '0;
                    ok     = 1'b1;
                end
            end
            OP_BLACKLIST:
            begin
                n_bl = 1'b1;
                ok   = 1'b1;
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase
    end

    assign entry_d = {n_st, n_bl, n_conf, n_pend, n_cur};

    always_comb
    begin
        res               = '0;
        res.ok            = ok;
        res.occupant_id   = 16'(n_cur);
        res.pending_id    = ((n_pend == n_cur) && !n_st) ? 16'd0 : 16'(n_pend);
        res.conflicted_id = 16'(n_conf);
        res.cell_usable   = !n_bl && (n_conf == '0);
        res.bad_coord     = 1'b0;
    end

endmodule

>>> rtl/grid_cell_occupancy_table_core.sv
`timescale 1ns / 1ps

// Occupancy table for an X_SIZE by Y_SIZE grid, cell (x, y) at index x*Y_SIZE+y, kept in one
// single-port-read, single-port-write RAM with one word per cell. After reset the block clears
// the RAM one cell per cycle and accepts no transfer until every cell is cleared. A place,
// purge, read or blacklist op then reads its cell from the RAM, modifies it and writes it back;
// the next op reads only after the write back, so no forwarding is needed. Undefined ops and
// out-of-range coordinates get their result without a RAM access. A commit streams through
// the cells in index order at one cell per cycle behind a registered RAM read and stops at the
// first contested cell. A finished result waits in an output register while the next transfer
// is taken; if that register is still full, the result is held and no transfer is taken.
module grid_cell_occupancy_table_core #(
    parameter int X_SIZE  = 64,
    parameter int Y_SIZE  = 64,
    parameter int ID_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // op[2:0], cell_x[8:3], cell_y[14:9], object_id[30:15], zero [31]
    input  logic [gcot_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ok[0], occupant_id[16:1], pending_id[32:17], conflicted_id[48:33],
    // cell_usable[49], bad_coord[50], zero [55:51]
    output logic [gcot_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    import gcot_pkg::*;

    localparam int NCELLS  = X_SIZE * Y_SIZE;
    localparam int IDX_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CNT_W   = $clog2(NCELLS + 1);
    localparam int ENTRY_W = 3 * ID_BITS + 2;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]   walk_rd_reg, walk_rd_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    op_t                op_reg, op_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    res_t               hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg, out_res_next;

    op_t                op_in;
    logic [5:0]         x_in;
    logic [5:0]         y_in;
    logic [ID_BITS-1:0] id_in;
    logic               in_range;
    logic [IDX_W-1:0]   idx_in;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_q;

    logic [ENTRY_W-1:0] cell_entry_d;
    res_t               cell_res;

    logic [ID_BITS-1:0] q_pend;
    logic [ID_BITS-1:0] q_conf;

    logic               emit_valid;
    res_t               emit_res;
    logic               out_free;
    logic               out_load;

    assign op_in    = op_t'(s_axis_tdata[2:0]);
    assign x_in     = s_axis_tdata[8:3];
    assign y_in     = s_axis_tdata[14:9];
    assign id_in    = ID_BITS'(s_axis_tdata[30:15]);
    assign in_range = (int'(x_in) < X_SIZE) && (int'(y_in) < Y_SIZE);
    assign idx_in   = IDX_W'(int'(x_in) * Y_SIZE + int'(y_in));

    assign q_pend = mem_q[2*ID_BITS-1:ID_BITS];
    assign q_conf = mem_q[3*ID_BITS-1:2*ID_BITS];

    assign out_free = !out_valid_reg || m_axis_tready;

    gcot_ram #(
        .DEPTH  (NCELLS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    gcot_cell #(
        .ID_BITS (ID_BITS)
    ) u_cell (
        .op      (op_reg),
        .id      (id_reg),
        .entry_q (mem_q),
        .entry_d (cell_entry_d),
        .res     (cell_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        walk_rd_next   = walk_rd_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        id_next        = id_reg;
        hold_next      = hold_reg;
        s_axis_tready  = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = cell_entry_d;
        mem_re         = 1'b0;
        mem_raddr      = idx_in;
        emit_valid     = 1'b0;
        emit_res       = '0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == IDX_W'(NCELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    op_next  = op_in;
                    idx_next = idx_in;
                    id_next  = id_in;
                    unique case (op_in) inside
                        OP_COMMIT:
                        begin
                            walk_rd_next   = '0;
                            chk_valid_next = 1'b0;
                            state_next     = ST_WALK;
                        end
                        OP_PLACE, OP_PURGE, OP_READ, OP_BLACKLIST:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_CELL;
                            end
                            else
                            begin
                                emit_valid         = 1'b1;
                                emit_res.bad_coord = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_CELL:
            begin
                mem_we     = 1'b1;
                emit_valid = 1'b1;
                emit_res   = cell_res;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                mem_raddr = walk_rd_reg[IDX_W-1:0];
                if (walk_rd_reg < CNT_W'(NCELLS))
                begin
                    mem_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = walk_rd_reg[IDX_W-1:0];
                    walk_rd_next   = walk_rd_reg + CNT_W'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg)
                begin
                    if (q_conf != '0)
                    begin
                        // stop at the first contested cell
                        emit_valid = 1'b1;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = chk_idx_reg;
                        mem_wdata = {2'b00, q_conf, q_pend, q_pend};
                        if (chk_idx_reg == IDX_W'(NCELLS - 1))
                        begin
                            emit_valid  = 1'b1;
                            emit_res.ok = 1'b1;
                        end
                    end
                end
            end
            ST_HOLD:
            begin
                emit_valid = 1'b1;
                emit_res   = hold_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit_valid)
        begin
            if (out_free)
            begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                hold_next  = emit_res;
                state_next = ST_HOLD;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_res_next   = emit_res;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
            out_res_next   = out_res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            walk_rd_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            walk_rd_reg   <= walk_rd_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        id_reg      <= id_next;
        hold_reg    <= hold_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_res_reg);

`ifndef SYNTHESIS
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("RAM read and write hit the same cell");

    a_cell_op_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && in_range
         && (op_in == OP_PLACE || op_in == OP_PURGE || op_in == OP_READ
             || op_in == OP_BLACKLIST)) |=> (state_reg == ST_CELL))
        else $error("cell op did not enter modify cycle");

    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && chk_valid_reg && walk_rd_reg != CNT_W'(NCELLS))
        |-> (walk_rd_reg == CNT_W'(chk_idx_reg) + CNT_W'(1)))
        else $error("commit walk read and check out of step");

    a_hold_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("result held while output register empty");
`endif

endmodule
